[rtl/core/mtt_pkg.sv]
// Package for the multi-timer table: codes, widths and the sweep token and command types.
// No dependencies.
`default_nettype none
package mtt_pkg;

	localparam int unsigned NUM_TIMERS_DEF = 16;
	localparam int unsigned MAX_FIRE       = 16;
	localparam int unsigned IDX_W          = 8;
	localparam int unsigned CNT_W          = 9;
	localparam int unsigned FIRE_W         = 5;

	localparam logic [2:0] MODE_START  = 3'd0;
	localparam logic [2:0] MODE_CANCEL = 3'd1;
	localparam logic [2:0] MODE_EXISTS = 3'd2;
	localparam logic [2:0] MODE_COUNT  = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;
	localparam logic [2:0] MODE_TICK   = 3'd5;
	localparam logic [2:0] MODE_RSV6   = 3'd6;
	localparam logic [2:0] MODE_RSV7   = 3'd7;

	localparam logic [1:0] SW_FREE  = 2'd0;
	localparam logic [1:0] SW_ID    = 2'd1;
	localparam logic [1:0] SW_COUNT = 2'd2;
	localparam logic [1:0] SW_MIN   = 2'd3;

	localparam logic [2:0] WR_NONE    = 3'd0;
	localparam logic [2:0] WR_START   = 3'd1;
	localparam logic [2:0] WR_KILL    = 3'd2;
	localparam logic [2:0] WR_REARM   = 3'd3;
	localparam logic [2:0] WR_CLEAR   = 3'd4;
	localparam logic [2:0] WR_CLRDONE = 3'd5;

	typedef struct packed {
		logic             vld;
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [63:0]      deadline;
		logic [31:0]      id;
		logic [31:0]      period;
		logic [CNT_W-1:0] cnt;
	} tok_t;

	typedef struct packed {
		logic [1:0]       sweep_op;
		logic [31:0]      qid;
		logic [63:0]      now;
		logic [2:0]       wr_kind;
		logic [IDX_W-1:0] wr_idx;
		logic [31:0]      wr_id;
		logic [63:0]      wr_deadline;
		logic [31:0]      wr_period;
	} cmd_t;

endpackage
`default_nettype wire

[rtl/core/mtt_req_if.sv]
// Request channel of the multi-timer table: valid/ready plus one request item.
// No dependencies.
`default_nettype none
interface mtt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] delay;
	logic [31:0] interval;
	logic [31:0] timer_id;

	modport source (output valid, mode, delay, interval, timer_id, input ready);
	modport sink (input valid, mode, delay, interval, timer_id, output ready);
endinterface
`default_nettype wire

[rtl/core/mtt_rsp_if.sv]
// Response channel of the multi-timer table: valid/ready plus one result item.
// No dependencies.
`default_nettype none
interface mtt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] fired_or_new_id;
	logic        ok;
	logic [4:0]  tally;
	logic        last;

	modport source (output valid, kind, fired_or_new_id, ok, tally, last, input ready);
	modport sink (input valid, kind, fired_or_new_id, ok, tally, last, output ready);
endinterface
`default_nettype wire

[rtl/core/mtt_cell.sv]
// One timer slot of the chain: holds the slot and updates the passing sweep token.
// Depends on mtt_pkg.
`default_nettype none
module mtt_cell
	import mtt_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire tok_t tok_in,
	output tok_t      tok_out
);

	logic        valid_q;
	logic        done_q;
	logic [31:0] id_q;
	logic [63:0] dl_q;
	logic [31:0] per_q;
	tok_t        tok_q;
	tok_t        tok_nxt;
	logic        sel;

	assign sel = (cmd.wr_idx == IDX[IDX_W-1:0]);

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.vld) begin
			case (cmd.sweep_op)
				SW_FREE: begin
					if (!tok_in.found && !valid_q) begin
						tok_nxt.found = 1'b1;
						tok_nxt.idx   = IDX[IDX_W-1:0];
					end
				end
				SW_ID: begin
					if (!tok_in.found && valid_q && id_q == cmd.qid) begin
						tok_nxt.found = 1'b1;
						tok_nxt.idx   = IDX[IDX_W-1:0];
					end
				end
				SW_COUNT: begin
					tok_nxt.cnt = tok_in.cnt + CNT_W'(valid_q);
				end
				SW_MIN: begin
					if (valid_q && !done_q && dl_q <= cmd.now &&
					    (!tok_in.found || dl_q < tok_in.deadline)) begin
						tok_nxt.found    = 1'b1;
						tok_nxt.idx      = IDX[IDX_W-1:0];
						tok_nxt.deadline = dl_q;
						tok_nxt.id       = id_q;
						tok_nxt.period   = per_q;
					end
				end
				default: tok_nxt = tok_in;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			case (cmd.wr_kind)
				WR_START: begin
					if (sel) begin
						valid_q <= 1'b1;
						done_q  <= 1'b0;
					end
				end
				WR_KILL: begin
					if (sel) valid_q <= 1'b0;
				end
				WR_REARM: begin
					if (sel) done_q <= 1'b1;
				end
				WR_CLEAR:   valid_q <= 1'b0;
				WR_CLRDONE: done_q  <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.wr_kind == WR_START) begin
			id_q  <= cmd.wr_id;
			dl_q  <= cmd.wr_deadline;
			per_q <= cmd.wr_period;
		end else if (sel && cmd.wr_kind == WR_REARM) begin
			dl_q <= cmd.wr_deadline;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

[rtl/core/mtt_ctl.sv]
// Sequencer of the multi-timer table: launches sweeps, commits slot writes, builds results.
// Depends on mtt_pkg, mtt_req_if and mtt_rsp_if.
`default_nettype none
module mtt_ctl
	import mtt_pkg::*;
#(
	parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mtt_req_if.sink    req,
	mtt_rsp_if.source  rsp,
	output cmd_t       cmd,
	output tok_t       tok_first,
	input  wire tok_t  tok_last
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LAUNCH = 3'd1;
	localparam logic [2:0] ST_WAIT   = 3'd2;
	localparam logic [2:0] ST_ARM1   = 3'd3;
	localparam logic [2:0] ST_ARM2   = 3'd4;
	localparam logic [2:0] ST_PUSH   = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0]        state_q;
	logic [2:0]        mode_q;
	logic [31:0]       delay_q;
	logic [31:0]       ival_q;
	logic [31:0]       qid_q;
	logic [63:0]       now_q;
	logic [31:0]       idc_q;
	logic [31:0]       idc_inc;
	tok_t              tok_q;
	logic [FIRE_W-1:0] k_q;
	logic              pend_vld_q;
	logic [31:0]       pend_id_q;
	logic [63:0]       sum1_q;
	logic [63:0]       sum2_q;
	logic [2:0]        res_kind_q;
	logic [31:0]       res_id_q;
	logic              res_ok_q;
	logic [4:0]        res_tally_q;
	logic              res_last_q;
	logic              out_vld_q;
	logic [2:0]        out_kind_q;
	logic [31:0]       out_id_q;
	logic              out_ok_q;
	logic [4:0]        out_tally_q;
	logic              out_last_q;
	logic              out_free;
	logic              accept;
	logic [4:0]        tally_sat;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_vld_q || rsp.ready;
	assign idc_inc  = idc_q + 32'd1;
	assign tally_sat = (tok_last.cnt > CNT_W'(31)) ? 5'd31 : tok_last.cnt[4:0];

	assign req.ready           = (state_q == ST_IDLE);
	assign rsp.valid           = out_vld_q;
	assign rsp.kind            = out_kind_q;
	assign rsp.fired_or_new_id = out_id_q;
	assign rsp.ok              = out_ok_q;
	assign rsp.tally           = out_tally_q;
	assign rsp.last            = out_last_q;

	always_comb begin
		tok_first     = '0;
		tok_first.vld = (state_q == ST_LAUNCH);
	end

	always_comb begin
		cmd             = '0;
		cmd.qid         = qid_q;
		cmd.now         = now_q;
		cmd.wr_kind     = WR_NONE;
		cmd.wr_idx      = tok_q.idx;
		cmd.wr_id       = idc_q;
		cmd.wr_deadline = now_q + {32'd0, delay_q};
		cmd.wr_period   = ival_q;
		case (mode_q)
			MODE_START:               cmd.sweep_op = SW_FREE;
			MODE_CANCEL, MODE_EXISTS: cmd.sweep_op = SW_ID;
			MODE_TICK:                cmd.sweep_op = SW_MIN;
			default:                  cmd.sweep_op = SW_COUNT;
		endcase
		case (state_q)
			ST_IDLE: begin
				if (accept && req.mode == MODE_TICK) cmd.wr_kind = WR_CLRDONE;
			end
			ST_WAIT: begin
				cmd.wr_idx = tok_last.idx;
				if (tok_last.vld) begin
					case (mode_q)
						MODE_START:  if (tok_last.found) cmd.wr_kind = WR_START;
						MODE_CANCEL: if (tok_last.found) cmd.wr_kind = WR_KILL;
						MODE_CLEAR:  cmd.wr_kind = WR_CLEAR;
						default:     cmd.wr_kind = WR_NONE;
					endcase
				end
			end
			ST_ARM2: begin
				cmd.wr_deadline = (sum1_q <= now_q) ? sum2_q : sum1_q;
				cmd.wr_kind     = (tok_q.period != 32'd0) ? WR_REARM : WR_KILL;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			idc_q      <= 32'd1;
			k_q        <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.mode == MODE_TICK) begin
							now_q      <= now_q + 64'd1;
							k_q        <= '0;
							pend_vld_q <= 1'b0;
						end
						state_q <= (req.mode inside {MODE_RSV6, MODE_RSV7}) ? ST_EMIT : ST_LAUNCH;
					end
				end
				ST_LAUNCH: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (tok_last.vld) begin
						state_q <= ST_EMIT;
						if (mode_q == MODE_START && tok_last.found)
							idc_q <= (idc_inc == 32'd0) ? 32'd1 : idc_inc;
						if (mode_q == MODE_TICK) begin
							if (tok_last.found) begin
								state_q <= ST_ARM1;
							end else if (pend_vld_q) begin
								pend_vld_q <= 1'b0;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_ARM1: state_q <= ST_ARM2;
				ST_ARM2: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (out_free) begin
						k_q <= k_q + FIRE_W'(1);
						if (k_q == FIRE_W'(MAX_FIRE - 1)) begin
							pend_vld_q <= 1'b0;
							state_q    <= ST_EMIT;
						end else begin
							pend_vld_q <= 1'b1;
							state_q    <= ST_LAUNCH;
						end
					end
				end
				ST_EMIT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= req.mode;
			delay_q     <= req.delay;
			ival_q      <= req.interval;
			qid_q       <= req.timer_id;
			res_kind_q  <= req.mode;
			res_id_q    <= '0;
			res_ok_q    <= 1'b0;
			res_tally_q <= '0;
			res_last_q  <= 1'b1;
		end
		if (state_q == ST_WAIT && tok_last.vld) begin
			tok_q       <= tok_last;
			res_kind_q  <= mode_q;
			res_id_q    <= '0;
			res_ok_q    <= 1'b0;
			res_tally_q <= '0;
			res_last_q  <= 1'b1;
			case (mode_q)
				MODE_START:               res_id_q    <= tok_last.found ? idc_q : 32'd0;
				MODE_CANCEL, MODE_EXISTS: res_ok_q    <= tok_last.found;
				MODE_COUNT, MODE_CLEAR:   res_tally_q <= tally_sat;
				MODE_TICK:                res_id_q    <= pend_id_q;
				default: ;
			endcase
		end
		if (state_q == ST_ARM1) begin
			sum1_q <= tok_q.deadline + {32'd0, tok_q.period};
			sum2_q <= now_q + {32'd0, tok_q.period};
		end
		if (state_q == ST_PUSH && out_free) begin
			pend_id_q   <= tok_q.id;
			res_kind_q  <= MODE_TICK;
			res_id_q    <= tok_q.id;
			res_ok_q    <= 1'b0;
			res_tally_q <= '0;
			res_last_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= (state_q == ST_EMIT) || (state_q == ST_PUSH && pend_vld_q);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_PUSH) begin
				out_kind_q  <= MODE_TICK;
				out_id_q    <= pend_id_q;
				out_ok_q    <= 1'b0;
				out_tally_q <= '0;
				out_last_q  <= 1'b0;
			end else begin
				out_kind_q  <= res_kind_q;
				out_id_q    <= res_id_q;
				out_ok_q    <= res_ok_q;
				out_tally_q <= res_tally_q;
				out_last_q  <= res_last_q;
			end
		end
	end

`ifndef ASSERT_OFF
	a_tok_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		tok_last.vld |-> state_q == ST_WAIT)
		else $error("sweep token arrived outside the wait state");
	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= FIRE_W'(MAX_FIRE))
		else $error("too many firings in one tick");
	a_pend_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_vld_q && state_q != ST_IDLE) |-> mode_q == MODE_TICK)
		else $error("pending expiry outside a tick");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready || mode_q == MODE_TICK)
		else $error("request taken while the previous one was in progress");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_last.vld && tok_last.found) |->
		{1'b0, tok_last.idx} < (IDX_W+1)'(NUM_TIMERS))
		else $error("sweep token points past the last slot");
`endif

endmodule
`default_nettype wire

[rtl/core/multi_timer_table_core.sv]
// Multi-timer table: top level, a chain of timer cells driven by the sequencer.
// Depends on mtt_pkg, mtt_req_if, mtt_rsp_if, mtt_cell and mtt_ctl.
//
// The table holds NUM_TIMERS one-shot or periodic timers, one per cell of a chain.
// Each request (start, cancel, exists, count, clear all, tick) is answered by a
// token that walks the chain one cell per cycle. Start, cancel, exists, count and
// clear all take one sweep and give one transaction. A tick runs one sweep per
// expiry plus a final empty sweep, which is left out at the cap of 16 expiries
// per tick; when nothing is due the tick gives no result. A stalled output holds
// the sequencer. A new request is taken once the previous one has handed over
// its last result, if any, to the output register.
`default_nettype none
module multi_timer_table_core
	import mtt_pkg::*;
#(
	parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mtt_req_if.sink   req,
	mtt_rsp_if.source rsp
);

	cmd_t cmd;
	tok_t chain [NUM_TIMERS+1];

	mtt_ctl #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.tok_first (chain[0]),
		.tok_last  (chain[NUM_TIMERS])
	);

	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
		mtt_cell #(
			.IDX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

endmodule
`default_nettype wire
